// ===== rtl/core/cga_tandy_vga_pixel_access_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pixel access engine
// Shared helpers for concurrent checks clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef CGA_TANDY_VGA_PIXEL_ACCESS_TOP_DEFINES_SVH
`define CGA_TANDY_VGA_PIXEL_ACCESS_TOP_DEFINES_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel access: same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel access: next-cycle check failed");

`endif

// ===== rtl/core/ctvpa_pkg.sv =====
// ---------------------------------------------------------------------------
// ctvpa_pkg
// Types and constants for the CGA/Tandy/VGA pixel access engine.
// ---------------------------------------------------------------------------
`default_nettype none

package ctvpa_pkg;

  localparam int STORE_ADDR_BITS = 17;
  localparam int BANK_IDX_BITS   = STORE_ADDR_BITS - 1;
  localparam int APB_ADDR_BITS   = 4;
  localparam int OFF_BITS        = 16;

  localparam logic [19:0] CGA_BASE   = 20'hB8000;
  localparam logic [19:0] VGA_BASE   = 20'hA0000;
  localparam logic [9:0]  ROW_RESET  = 10'd160;
  localparam logic [9:0]  CGA_ROW    = 10'd80;
  localparam logic [9:0]  CGA32_ROW  = 10'd160;
  localparam logic [9:0]  VGA_ROW    = 10'd320;

  typedef enum logic [2:0] {
    MODE_CGA4_16K  = 3'd0,
    MODE_CGA4_32K  = 3'd1,
    MODE_CGA2      = 3'd2,
    MODE_TANDY_16K = 3'd3,
    MODE_TANDY_32K = 3'd4,
    MODE_VGA256    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE_KIND       = 2'd0,
    REG_IS_PCJR         = 2'd1,
    REG_CPU_PAGE        = 2'd2,
    REG_TANDY_ROW_BYTES = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CALC  = 5'b00100,
    S_READ  = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/cga_tandy_vga_pixel_access_top.sv =====
// ---------------------------------------------------------------------------
// cga_tandy_vga_pixel_access_top
// Pixel put/get engine over a 128 KB interleaved video store.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive op, pos_x, pos_y, pixel_color with start; the word
//   is taken at a clock edge where start is high and busy is low.
//   Result channel: done is high for one cycle with pixel_value and
//   byte_address; there is no backpressure, the receiver must take it.
//   Config: APB write/read of mode_kind, is_pcjr, cpu_page, tandy_row_bytes
//   at byte offsets 0, 4, 8, 12; pready is tied high. Write only while idle.
// Timing:
//   Accept edge, then address calc, store read, modify/write; done is registered
//   from the write state. A new word can be taken in the cycle done is high.
//   The limit is the read-modify-write through the single-port store banks,
//   one access per item.
// Reset:
//   rst restores the register defaults and starts a clearing pass over the
//   store, two bytes per cycle, with busy high.
// Store is split into even/odd byte banks so the two-plane CGA 32k layout
//   reads and writes its byte pair in one access.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cga_tandy_vga_pixel_access_top_defines.svh"

module cga_tandy_vga_pixel_access_top
  import ctvpa_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  // command
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic                       op,
  input  wire logic [9:0]                 pos_x,
  input  wire logic [8:0]                 pos_y,
  input  wire logic [7:0]                 pixel_color,
  // result
  output      logic                       done,
  output      logic [7:0]                 pixel_value,
  output      logic [STORE_ADDR_BITS-1:0] byte_address,
  // config
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [APB_ADDR_BITS-1:0]   paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready
);

  // config registers
  logic [2:0] mode_kind;
  logic       is_pcjr;
  logic [2:0] cpu_page;
  logic [9:0] tandy_row_bytes;

  // control
  state_t                   state, state_next;
  logic [BANK_IDX_BITS-1:0] clr_idx;

  // latched command word
  logic       op_q;
  logic [9:0] x_q;
  logic [8:0] y_q;
  logic [7:0] c_q;

  logic [STORE_ADDR_BITS-1:0] addr, addr_next;

  // store banks
  logic [7:0] even_mem [2**BANK_IDX_BITS];
  logic [7:0] odd_mem  [2**BANK_IDX_BITS];
  logic [7:0] even_rd, odd_rd;

  logic                     even_we, odd_we;
  logic [BANK_IDX_BITS-1:0] wr_idx;
  logic [7:0]               even_wd, odd_wd;

  logic cfg_wr;
  logic accept;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // -------------------------------------------------------------------------
  // APB register file
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_kind       <= 3'd0;
      is_pcjr         <= 1'b0;
      cpu_page        <= 3'd0;
      tandy_row_bytes <= ROW_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MODE_KIND:       mode_kind       <= pwdata[2:0];
        REG_IS_PCJR:         is_pcjr         <= pwdata[0];
        REG_CPU_PAGE:        cpu_page        <= pwdata[2:0];
        REG_TANDY_ROW_BYTES: tandy_row_bytes <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE_KIND:       prdata = {29'd0, mode_kind};
      REG_IS_PCJR:         prdata = {31'd0, is_pcjr};
      REG_CPU_PAGE:        prdata = {29'd0, cpu_page};
      REG_TANDY_ROW_BYTES: prdata = {22'd0, tandy_row_bytes};
      default:             prdata = 32'd0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_idx == '1) state_next = S_IDLE;
      S_IDLE:  if (start)         state_next = S_CALC;
      S_CALC:                     state_next = S_READ;
      S_READ:                     state_next = S_WRITE;
      S_WRITE:                    state_next = S_IDLE;
      default:                    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= op;
      x_q  <= pos_x;
      y_q  <= pos_y;
      c_q  <= pixel_color;
    end
  end

  // -------------------------------------------------------------------------
  // Address: one shared row multiply, column and bank terms, window base
  // -------------------------------------------------------------------------
  logic [8:0]          mul_a;
  logic [9:0]          mul_b;
  logic [18:0]         prod;
  logic [OFF_BITS-1:0] col_term, bank_term, off;
  logic [19:0]         base;
  logic                mode_ok;
  logic [19:0]         wide_base;

  assign wide_base = is_pcjr ? {3'd0, cpu_page, 14'd0} : CGA_BASE;

  always_comb begin
    mul_a     = 9'd0;
    mul_b     = 10'd0;
    col_term  = '0;
    bank_term = '0;
    base      = CGA_BASE;
    mode_ok   = 1'b1;
    case (mode_kind)
      MODE_CGA4_16K: begin
        mul_a     = {1'b0, y_q[8:1]};
        mul_b     = CGA_ROW;
        col_term  = OFF_BITS'(x_q[9:2]);
        bank_term = {2'd0, y_q[0], 13'd0};
      end
      MODE_CGA4_32K: begin
        mul_a     = {2'd0, y_q[8:2]};
        mul_b     = CGA32_ROW;
        col_term  = OFF_BITS'({x_q[9:3], 1'b0});
        bank_term = {1'b0, y_q[1:0], 13'd0};
        base      = wide_base;
      end
      MODE_CGA2: begin
        mul_a     = {1'b0, y_q[8:1]};
        mul_b     = CGA_ROW;
        col_term  = OFF_BITS'(x_q[9:3]);
        bank_term = {2'd0, y_q[0], 13'd0};
      end
      MODE_TANDY_16K: begin
        mul_a     = {1'b0, y_q[8:1]};
        mul_b     = tandy_row_bytes;
        col_term  = OFF_BITS'(x_q[9:1]);
        bank_term = {2'd0, y_q[0], 13'd0};
      end
      MODE_TANDY_32K: begin
        mul_a     = {2'd0, y_q[8:2]};
        mul_b     = tandy_row_bytes;
        col_term  = OFF_BITS'(x_q[9:1]);
        bank_term = {1'b0, y_q[1:0], 13'd0};
        base      = wide_base;
      end
      MODE_VGA256: begin
        mul_a     = y_q;
        mul_b     = VGA_ROW;
        col_term  = OFF_BITS'(x_q);
        base      = VGA_BASE;
      end
      default: mode_ok = 1'b0;
    endcase
  end

  assign prod = 19'(mul_a * mul_b);
  assign off  = prod[OFF_BITS-1:0] + col_term + bank_term;
  assign addr_next = mode_ok ? STORE_ADDR_BITS'(base + {4'd0, off}) : '0;

  always_ff @(posedge clk) begin
    if (state == S_CALC) addr <= addr_next;
  end

  // -------------------------------------------------------------------------
  // Modify: merge or XOR pixel bits, or pull them out for a get
  // -------------------------------------------------------------------------
  logic [7:0] byte_sel, fld, msk, new_byte, lo_new, hi_new, val;
  logic [7:0] lo_bit, hi_bit;
  logic [2:0] sh2, sh1, shn;
  logic       xr, hit_lo, hit_hi;

  assign byte_sel = addr[0] ? odd_rd : even_rd;
  assign xr       = c_q[7];
  assign sh2      = {~x_q[1:0], 1'b0};
  assign sh1      = ~x_q[2:0];
  assign shn      = x_q[0] ? 3'd0 : 3'd4;
  assign lo_bit   = 8'(c_q[0]) << sh1;
  assign hi_bit   = 8'(c_q[1]) << sh1;
  assign msk      = 8'd1 << sh1;
  assign hit_lo   = |(even_rd & msk);
  assign hit_hi   = |(odd_rd & msk);

  always_comb begin
    fld      = 8'd0;
    new_byte = byte_sel;
    lo_new   = even_rd;
    hi_new   = odd_rd;
    val      = 8'd0;
    case (mode_kind)
      MODE_CGA4_16K: begin
        fld      = 8'(c_q[1:0]) << sh2;
        new_byte = xr ? (byte_sel ^ fld) : ((byte_sel & ~(8'd3 << sh2)) | fld);
        val      = (byte_sel >> sh2) & 8'd3;
      end
      MODE_CGA4_32K: begin
        lo_new = xr ? (even_rd ^ lo_bit) : ((even_rd & ~msk) | lo_bit);
        hi_new = xr ? (odd_rd ^ hi_bit) : ((odd_rd & ~msk) | hi_bit);
        val    = {6'd0, hit_hi, hit_lo};
      end
      MODE_CGA2: begin
        fld      = lo_bit;
        new_byte = xr ? (byte_sel ^ fld) : ((byte_sel & ~msk) | fld);
        val      = {7'd0, |(byte_sel & msk)};
      end
      MODE_TANDY_16K, MODE_TANDY_32K: begin
        fld      = 8'(c_q[3:0]) << shn;
        new_byte = xr ? (byte_sel ^ fld) : ((byte_sel & ~(8'hF << shn)) | fld);
        val      = (byte_sel >> shn) & 8'hF;
      end
      MODE_VGA256: begin
        new_byte = c_q;
        val      = byte_sel;
      end
      default: ;
    endcase
  end

  // write port mux: clearing pass or the put of the current word
  logic put_wr, pair_mode, single_mode;

  assign put_wr      = (state == S_WRITE) && !op_q;
  assign pair_mode   = (mode_kind == MODE_CGA4_32K);
  assign single_mode = mode_ok && !pair_mode;

  always_comb begin
    if (state == S_CLEAR) begin
      even_we = 1'b1;
      odd_we  = 1'b1;
      wr_idx  = clr_idx;
      even_wd = 8'd0;
      odd_wd  = 8'd0;
    end else begin
      // cga4_32k addresses are always even: low plane even bank, high odd
      even_we = put_wr && (pair_mode || (single_mode && !addr[0]));
      odd_we  = put_wr && (pair_mode || (single_mode && addr[0]));
      wr_idx  = addr[STORE_ADDR_BITS-1:1];
      even_wd = pair_mode ? lo_new : new_byte;
      odd_wd  = pair_mode ? hi_new : new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (even_we) even_mem[wr_idx] <= even_wd;
    if (state == S_READ) even_rd <= even_mem[addr[STORE_ADDR_BITS-1:1]];
  end

  always_ff @(posedge clk) begin
    if (odd_we) odd_mem[wr_idx] <= odd_wd;
    if (state == S_READ) odd_rd <= odd_mem[addr[STORE_ADDR_BITS-1:1]];
  end

  // -------------------------------------------------------------------------
  // Result word
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (state == S_WRITE);
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      pixel_value  <= op_q ? val : 8'd0;
      byte_address <= addr;
    end
  end

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `ASSERT_NEXT(a_accept_to_calc, start && !busy, state == S_CALC)
  `ASSERT_IMPLIES(a_done_after_write, done, $past(state == S_WRITE))
  `ASSERT_IMPLIES(a_put_reads_zero, done && !op_q, pixel_value == 8'd0)
  `ASSERT_IMPLIES(a_pair_even, done && (mode_kind == MODE_CGA4_32K), !byte_address[0])
  `ASSERT_IMPLIES(a_no_write_idle, state == S_IDLE, !even_we && !odd_we)

endmodule

`default_nettype wire
